### hw/rtl/rpti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = 10;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_W       = 31;
  localparam int POS_W       = 2 * CFG_W;
  localparam int PROD_W      = DATA_W + FRAC_W + 2;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] RADIUS_RST      = 31'd157286;
  localparam logic [CFG_W-1:0] INDEX_SCALE_RST = 31'd27934720;

  typedef enum logic [1:0] {
    OP_WR_PROFILE  = 2'd0,
    OP_WR_GRADIENT = 2'd1,
    OP_EVAL        = 2'd2,
    OP_NOP         = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_RADIUS      = 1'b0,
    CFG_INDEX_SCALE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_WR_PROFILE  = 2'd0,
    KIND_WR_GRADIENT = 2'd1,
    KIND_EVAL        = 2'd2
  } kind_t;

  // one classified transaction between front and back
  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
    logic                outside;
    logic [FRAC_W-1:0]   frac;
  } item_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
    logic               busy;
  } qstat_t;

endpackage
`default_nettype wire

### hw/rtl/rpti_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rpti_front
  import rpti_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [1:0]          operation,
  input  wire logic [IDX_W-1:0]    entry_index,
  input  wire logic [DATA_W-1:0]   entry_data,
  input  wire logic [DATA_W-1:0]   radial_distance,
  input  wire logic [CFG_W-1:0]    radius,
  input  wire logic [CFG_W-1:0]    index_scale,
  output logic                     push,
  output item_t                    push_item
);

  logic                f1_vld_r;
  kind_t               f1_kind_r;
  logic [ADDR_W-1:0]   f1_addr_r;
  logic [DATA_W-1:0]   f1_data_r;
  logic [CFG_W-1:0]    f1_dist_r;

  logic                keep;
  kind_t               kind;
  logic [CFG_W-1:0]    dist_abs;
  logic [DATA_W-1:0]   dist_neg;
  logic                widx_ok;

  logic                f2_vld_r;
  item_t               f2_item_r;
  item_t               f2_item_nxt;
  logic [POS_W-1:0]    pos;
  logic [POS_W-33:0]   pos_idx;

  assign widx_ok  = 32'(entry_index) < 32'(TABLE_DEPTH);
  assign dist_neg = -radial_distance;

  // magnitude, saturating the most negative input
  always_comb begin
    if (radial_distance == {1'b1, {(DATA_W-1){1'b0}}}) begin
      dist_abs = {CFG_W{1'b1}};
    end else if (radial_distance[DATA_W-1]) begin
      dist_abs = dist_neg[CFG_W-1:0];
    end else begin
      dist_abs = radial_distance[CFG_W-1:0];
    end
  end

  always_comb begin
    keep = 1'b0;
    kind = KIND_EVAL;
    unique case (op_t'(operation))
      OP_WR_PROFILE: begin
        keep = widx_ok;
        kind = KIND_WR_PROFILE;
      end
      OP_WR_GRADIENT: begin
        keep = widx_ok;
        kind = KIND_WR_GRADIENT;
      end
      OP_EVAL: begin
        keep = 1'b1;
        kind = KIND_EVAL;
      end
      OP_NOP: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= accept && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_kind_r <= kind;
      f1_addr_r <= ADDR_W'(entry_index);
      f1_data_r <= entry_data;
      f1_dist_r <= dist_abs;
    end
  end

  // scale to table position: integer part indexes, upper fraction bits weight
  assign pos     = {{CFG_W{1'b0}}, f1_dist_r} * {{CFG_W{1'b0}}, index_scale};
  assign pos_idx = pos[POS_W-1:32];

  always_comb begin
    f2_item_nxt.kind    = f1_kind_r;
    f2_item_nxt.data    = f1_data_r;
    f2_item_nxt.outside = 1'b0;
    f2_item_nxt.addr    = f1_addr_r;
    f2_item_nxt.frac    = '0;
    if (f1_kind_r == KIND_EVAL) begin
      f2_item_nxt.outside = f1_dist_r >= radius;
      if (32'(pos_idx) >= 32'(TABLE_DEPTH - 1)) begin
        f2_item_nxt.addr = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
        f2_item_nxt.addr = ADDR_W'(pos_idx);
        f2_item_nxt.frac = pos[31:32-FRAC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_vld_r) begin
      f2_item_r <= f2_item_nxt;
    end
  end

  assign push      = f2_vld_r;
  assign push_item = f2_item_r;

endmodule
`default_nettype wire

### hw/rtl/rpti_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rpti_queue
  import rpti_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output qstat_t     stat
);

  item_t                entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;
  logic [Q_CNT_W-1:0]   count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = count_r == '0;
  // leave room for the two transactions that may sit in the front stages
  assign stat.busy  = 32'(count_r) >= 32'(Q_DEPTH - 2);

endmodule
`default_nettype wire

### hw/rtl/rpti_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rpti_back
  import rpti_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire item_t               head,
  input  wire logic                pop,
  output logic                     out_valid,
  output logic [DATA_W-1:0]        out_profile_value,
  output logic [DATA_W-1:0]        out_gradient_value,
  output logic                     out_outside_radius
);

  logic [DATA_W-1:0]   prof_mem [TABLE_DEPTH];
  logic [DATA_W-1:0]   grad_mem [TABLE_DEPTH];

  logic [ADDR_W-1:0]   addr_hi;
  logic                rd_en;

  logic                b1_vld_r;
  logic                b1_outside_r;
  logic [FRAC_W-1:0]   b1_frac_r;
  logic [DATA_W-1:0]   prof_lo_r, prof_hi_r, grad_lo_r, grad_hi_r;

  logic [FRAC_W:0]     w_lo;
  logic                b2_vld_r;
  logic                b2_outside_r;
  logic signed [PROD_W-1:0] prof_plo_r, prof_phi_r, grad_plo_r, grad_phi_r;

  logic signed [PROD_W-1:0] prof_sum, grad_sum;

  logic                out_vld_r;
  logic [DATA_W-1:0]   out_prof_r, out_grad_r;
  logic                out_outside_r;

  // right neighbour only carries weight when the fraction is nonzero
  assign addr_hi = (head.frac == '0) ? head.addr : head.addr + 1'b1;
  assign rd_en   = pop && (head.kind == KIND_EVAL);

  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_WR_PROFILE) begin
      prof_mem[head.addr] <= head.data;
    end
    if (rd_en) begin
      prof_lo_r <= prof_mem[head.addr];
      prof_hi_r <= prof_mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_WR_GRADIENT) begin
      grad_mem[head.addr] <= head.data;
    end
    if (rd_en) begin
      grad_lo_r <= grad_mem[head.addr];
      grad_hi_r <= grad_mem[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      b1_outside_r <= head.outside;
      b1_frac_r    <= head.frac;
    end
  end

  assign w_lo = {1'b1, {FRAC_W{1'b0}}} - {1'b0, b1_frac_r};

  always_ff @(posedge clk) begin
    if (b1_vld_r) begin
      b2_outside_r <= b1_outside_r;
      prof_plo_r   <= PROD_W'($signed(prof_lo_r) * $signed({1'b0, w_lo}));
      prof_phi_r   <= PROD_W'($signed(prof_hi_r) * $signed({2'b00, b1_frac_r}));
      grad_plo_r   <= PROD_W'($signed(grad_lo_r) * $signed({1'b0, w_lo}));
      grad_phi_r   <= PROD_W'($signed(grad_hi_r) * $signed({2'b00, b1_frac_r}));
    end
  end

  assign prof_sum = prof_plo_r + prof_phi_r;
  assign grad_sum = grad_plo_r + grad_phi_r;

  // bit slice of the two's complement sum floors the division
  always_ff @(posedge clk) begin
    if (b2_vld_r) begin
      out_outside_r <= b2_outside_r;
      out_prof_r    <= b2_outside_r ? '0 : prof_sum[DATA_W+FRAC_W-1:FRAC_W];
      out_grad_r    <= b2_outside_r ? '0 : grad_sum[DATA_W+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      b1_vld_r  <= rd_en;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= b2_vld_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_profile_value  = out_prof_r;
  assign out_gradient_value = out_grad_r;
  assign out_outside_radius = out_outside_r;

endmodule
`default_nettype wire

### hw/rtl/radial_profile_table_interpolator_top.sv
// An accepted evaluate passes the front-end registers, a queue entry, the table read
//   register and the product register to the result register that drives out_valid.
// Throughput: one transaction per cycle unless busy; the back end retires one queue entry
//   each cycle (one dual-read of each table memory), so busy stays low in normal use.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
// Reset (rst_n, synchronous, active low) empties the pipeline and queue and restores
//   radius and index_scale; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module radial_profile_table_interpolator_top
  import rpti_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_operation,
  input  wire logic [IDX_W-1:0]    in_entry_index,
  input  wire logic [DATA_W-1:0]   in_entry_data,
  input  wire logic [DATA_W-1:0]   in_radial_distance,
  output logic                     out_valid,
  output logic [DATA_W-1:0]        out_profile_value,
  output logic [DATA_W-1:0]        out_gradient_value,
  output logic                     out_outside_radius,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  logic [CFG_W-1:0] radius_r;
  logic [CFG_W-1:0] radius_nxt;
  logic [CFG_W-1:0] index_scale_r;
  logic [CFG_W-1:0] index_scale_nxt;

  logic   accept;
  logic   push;
  item_t  push_item;
  item_t  head;
  logic   pop;
  qstat_t qstat;

  // Configuration: the user writes it only while idle (unchecked here), so take the value at once.
  always_comb begin
    radius_nxt      = radius_r;
    index_scale_nxt = index_scale_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIUS:      radius_nxt      = cfg_wdata;
        CFG_INDEX_SCALE: index_scale_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= RADIUS_RST;
      index_scale_r <= INDEX_SCALE_RST;
    end else begin
      radius_r      <= radius_nxt;
      index_scale_r <= index_scale_nxt;
    end
  end

  // Hold off new transactions only when the queue is close to full.
  assign busy   = qstat.busy;
  assign accept = start && !busy;

  // Front end: classify, drop no-ops and out-of-range writes, take the magnitude,
  // compare against the radius and scale to a table position.
  rpti_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .operation       (in_operation),
    .entry_index     (in_entry_index),
    .entry_data      (in_entry_data),
    .radial_distance (in_radial_distance),
    .radius          (radius_r),
    .index_scale     (index_scale_r),
    .push            (push),
    .push_item       (push_item)
  );

  // Short queue decouples the two halves; writes and evaluates stay in order.
  rpti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  // Back end never stalls: advance whenever an entry is waiting.
  assign pop = !qstat.empty;

  // Back end: table writes, neighbour reads, weighted blend, result register.
  rpti_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_profile_value  (out_profile_value),
    .out_gradient_value (out_gradient_value),
    .out_outside_radius (out_outside_radius)
  );

  // An outside result carries zero values.
  a_outside_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outside_radius) |-> (out_profile_value == '0 &&
                                           out_gradient_value == '0))
    else $error("outside result with nonzero value");

  // The queue never holds more than its depth.
  a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
    32'(qstat.count) <= 32'(Q_DEPTH))
    else $error("queue overflow");

  // Every accepted evaluate is followed by its out_valid strobe.
  a_eval_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_EVAL) |-> ##6 out_valid)
    else $error("evaluate result missing");

  // No strobe without an earlier accepted evaluate.
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && in_operation == OP_EVAL, 6))
    else $error("unexpected result strobe");

endmodule
`default_nettype wire

### verif/tb_radial_profile_table_interpolator_top.sv
`timescale 1ns / 1ps
module tb_radial_profile_table_interpolator_top;
  import rpti_pkg::*;

  // Pause after the last expected result; this covers any write still in the pipeline
  // with margin.
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int LAST_ENTRY      = TABLE_DEPTH - 1;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;

  typedef struct packed {
    logic [DATA_W-1:0] profile;
    logic [DATA_W-1:0] gradient;
    logic              outside;
  } eval_result_t;

  // Directed stimulus row; result is only used where pinned is set
  typedef struct {
    op_t               op;
    logic [IDX_W-1:0]  entry;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] distance;
    bit                pinned;
    eval_result_t      result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [IDX_W-1:0] in_entry_index = '0;
  logic [DATA_W-1:0] in_entry_data = '0;
  logic [DATA_W-1:0] in_radial_distance = '0;
  logic out_valid;
  logic [DATA_W-1:0] out_profile_value;
  logic [DATA_W-1:0] out_gradient_value;
  logic out_outside_radius;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Carried alongside each transaction so the monitor knows whether the
  // expected result is typed in by hand
  bit row_pinned = 1'b0;
  eval_result_t row_result = '0;

  // Shadow of the block: both tables and the two registers
  logic [DATA_W-1:0] profile_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] gradient_mem [TABLE_DEPTH];
  logic [CFG_W-1:0] radius_cfg = RADIUS_RST;
  logic [CFG_W-1:0] scale_cfg = INDEX_SCALE_RST;
  // Entries already written in stimulus order; no evaluate may touch others
  bit profile_loaded [TABLE_DEPTH];
  bit gradient_loaded [TABLE_DEPTH];
  eval_result_t pending_evals [$];

  int mismatches = 0;
  int cycle_count = 0;
  int sent = 0;
  int evals_checked = 0;
  int burst_left = 1;

  directed_row_t directed_rows [21] = '{
    // extremes of the sample range at the low end of the table, other values at the top
    '{OP_WR_PROFILE,  10'd0,    32'h7FFF_FFFF, 32'd0, 1'b0, '0},
    '{OP_WR_GRADIENT, 10'd0,    32'h8000_0000, 32'd0, 1'b0, '0},
    '{OP_WR_PROFILE,  10'd1,    32'h8000_0000, 32'd0, 1'b0, '0},
    '{OP_WR_GRADIENT, 10'd1,    32'h7FFF_FFFF, 32'd0, 1'b0, '0},
    '{OP_WR_PROFILE,  10'd1023, 32'h1234_5678, 32'd0, 1'b0, '0},
    '{OP_WR_GRADIENT, 10'd1023, 32'hEDCB_A988, 32'd0, 1'b0, '0},
    '{OP_WR_PROFILE,  10'd1022, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
    '{OP_WR_GRADIENT, 10'd1022, 32'h0000_0001, 32'd0, 1'b0, '0},
    // zero distance reads entry 0 untouched
    '{OP_EVAL, 10'd0, 32'd0, 32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
    // smallest steps either side of the centre, and about half way to entry 1
    '{OP_EVAL, 10'd0, 32'd0, 32'h0000_0001, 1'b0, '0},
    '{OP_EVAL, 10'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_EVAL, 10'd0, 32'd0, 32'd77,        1'b0, '0},
    // most negative distance saturates, so it is outside; so is the largest positive one
    '{OP_EVAL, 10'd0, 32'd0, 32'h8000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
    '{OP_EVAL, 10'd0, 32'd0, 32'h7FFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b1}},
    // exactly on the radius, both signs
    '{OP_EVAL, 10'd0, 32'd0, 32'd157286,    1'b1, '{32'd0, 32'd0, 1'b1}},
    '{OP_EVAL, 10'd0, 32'd0, 32'hFFFD_999A, 1'b1, '{32'd0, 32'd0, 1'b1}},
    // just inside the radius, top pair of entries
    '{OP_EVAL, 10'd0, 32'd0, 32'd157285,    1'b0, '0},
    '{OP_EVAL, 10'd0, 32'd0, 32'hFFFD_99F0, 1'b0, '0},
    // unused operation code: no result
    '{OP_NOP, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    // overwrite then read straight back
    '{OP_WR_PROFILE, 10'd0, 32'h0000_0000, 32'd0, 1'b0, '0},
    '{OP_EVAL, 10'd0, 32'd0, 32'h0000_0000, 1'b1, '{32'd0, 32'h8000_0000, 1'b0}}
  };

  radial_profile_table_interpolator_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_entry_index     (in_entry_index),
    .in_entry_data      (in_entry_data),
    .in_radial_distance (in_radial_distance),
    .out_valid          (out_valid),
    .out_profile_value  (out_profile_value),
    .out_gradient_value (out_gradient_value),
    .out_outside_radius (out_outside_radius),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Absolute distance; the most negative input saturates to full scale
  function automatic logic [31:0] magnitude(input logic [31:0] distance);
    if (distance == 32'h8000_0000) return 32'h7FFF_FFFF;
    return distance[31] ? -distance : distance;
  endfunction

  // Position of a distance in the table under the current registers
  function automatic void locate(input logic [31:0] distance, output bit outside,
                                 output logic [31:0] entry, output logic [15:0] frac);
    logic [31:0] d;
    logic [63:0] pos;
    d = magnitude(distance);
    pos = 64'(d) * 64'(scale_cfg);
    outside = d >= 32'(radius_cfg);
    entry = pos[63:32];
    frac = pos[31:16];
  endfunction

  // Weighted mean of two neighbours, rounded towards minus infinity
  function automatic logic [31:0] blend(input logic signed [31:0] left,
                                        input logic signed [31:0] right,
                                        input logic [15:0] frac);
    longint sum;
    sum = longint'(left) * (longint'(65536) - longint'(frac))
        + longint'(right) * longint'(frac);
    return 32'(sum >>> 16);
  endfunction

  function automatic eval_result_t interpolate_at(input logic [31:0] distance);
    eval_result_t r;
    bit outside;
    logic [31:0] entry;
    logic [15:0] frac;
    locate(distance, outside, entry, frac);
    r = '0;
    r.outside = outside;
    if (!outside) begin
      if (entry >= LAST_ENTRY) begin
        // past the end of the table: hold the last entry
        r.profile = profile_mem[LAST_ENTRY];
        r.gradient = gradient_mem[LAST_ENTRY];
      end else begin
        r.profile = blend(profile_mem[entry], profile_mem[entry + 1], frac);
        r.gradient = blend(gradient_mem[entry], gradient_mem[entry + 1], frac);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted transactions and result strobes, all
  // sampled at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic check_result();
    eval_result_t want;
    if (pending_evals.size() == 0) begin
      report_mismatch("result with none pending", 32'd0, out_profile_value);
    end else begin
      want = pending_evals.pop_front();
      evals_checked++;
      if (out_profile_value !== want.profile)
        report_mismatch("profile_value", want.profile, out_profile_value);
      if (out_gradient_value !== want.gradient)
        report_mismatch("gradient_value", want.gradient, out_gradient_value);
      if (out_outside_radius !== want.outside)
        report_mismatch("outside_radius", 32'(want.outside), 32'(out_outside_radius));
    end
  endtask

  task automatic take_transaction();
    case (op_t'(in_operation))
      OP_WR_PROFILE:  profile_mem[in_entry_index] = in_entry_data;
      OP_WR_GRADIENT: gradient_mem[in_entry_index] = in_entry_data;
      OP_EVAL:        pending_evals.push_back(row_pinned ? row_result
                                                         : interpolate_at(in_radial_distance));
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RADIUS:      radius_cfg = cfg_wdata;
          CFG_INDEX_SCALE: scale_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid) check_result();
      if (start && !busy) take_transaction();
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------

  // Hold start low until every expected result is in, then let the pipeline empty
  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (pending_evals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic issue(input op_t op, input logic [IDX_W-1:0] entry,
                       input logic [DATA_W-1:0] data, input logic [DATA_W-1:0] distance,
                       input bit pinned, input eval_result_t result);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_entry_index <= entry;
    in_entry_data <= data;
    in_radial_distance <= distance;
    row_pinned <= pinned;
    row_result <= result;
    if (op == OP_WR_PROFILE) profile_loaded[entry] = 1'b1;
    if (op == OP_WR_GRADIENT) gradient_loaded[entry] = 1'b1;
    // hold the transaction until the block takes it
    do @(posedge clk); while (busy);
    sent++;
    // sender bursts: at the end of each, idle a while or occasionally drain
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end else begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 4);
        @(negedge clk) start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic write_reg(input cfg_idx_t which, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Distance for an evaluate: half aimed at a chosen entry with a random fraction,
  // the rest raw, near the radius, at the extremes or small
  function automatic logic [31:0] pick_distance();
    int unsigned k;
    logic [63:0] target;
    logic [31:0] d;
    d = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        case ($urandom_range(0, 3))
          0:       k = $urandom_range(0, 3);
          1:       k = $urandom_range(LAST_ENTRY - 3, LAST_ENTRY);
          default: k = $urandom_range(0, LAST_ENTRY);
        endcase
        target = {32'(k), 16'($urandom), 16'h0000};
        if (scale_cfg == '0) begin
          d = $urandom_range(0, 32'h7FFF_FFFF);
        end else begin
          target = (target + 64'(scale_cfg) - 64'd1) / 64'(scale_cfg);
          d = (target > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : target[31:0];
        end
      end
      5, 6: return $urandom;
      7: d = 32'(radius_cfg) + 32'($urandom_range(0, 2)) - 32'd1;
      8: begin
        case ($urandom_range(0, 2))
          0:       return 32'h8000_0000;
          1:       d = 32'h7FFF_FFFF;
          default: d = '0;
        endcase
      end
      default: d = $urandom_range(0, 32'h000F_FFFF);
    endcase
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // Load whichever entries the evaluate will weight and that are still blank;
  // now and then rewrite them anyway so a write lands right before its read
  task automatic load_neighbours(input logic [31:0] distance);
    bit outside;
    logic [31:0] entry;
    logic [15:0] frac;
    int first;
    int last;
    locate(distance, outside, entry, frac);
    if (outside) return;
    if (entry >= LAST_ENTRY) begin
      first = LAST_ENTRY;
      last = LAST_ENTRY;
    end else begin
      first = int'(entry);
      last = (frac != '0) ? first + 1 : first;
    end
    for (int e = first; e <= last; e++) begin
      if (!profile_loaded[e] || $urandom_range(0, 7) == 0)
        issue(OP_WR_PROFILE, IDX_W'(e), random_sample(), $urandom, 1'b0, '0);
      if (!gradient_loaded[e] || $urandom_range(0, 7) == 0)
        issue(OP_WR_GRADIENT, IDX_W'(e), random_sample(), $urandom, 1'b0, '0);
    end
  endtask

  // Issue transactions until about count more have gone in, loads included
  task automatic run_random(input int count);
    int pick;
    int stop;
    logic [31:0] distance;
    stop = sent + count;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue($urandom_range(0, 1) ? OP_WR_GRADIENT : OP_WR_PROFILE,
              IDX_W'($urandom), random_sample(), $urandom, 1'b0, '0);
      end else if (pick < 35) begin
        issue(OP_NOP, IDX_W'($urandom), $urandom, $urandom, 1'b0, '0);
      end else begin
        distance = pick_distance();
        load_neighbours(distance);
        issue(OP_EVAL, IDX_W'($urandom), $urandom, distance, 1'b0, '0);
      end
    end
  endtask

  // Register settings per phase: the extremes in phases 1 to 4 and 7, the others
  // matched to the table so the whole depth is used
  task automatic set_phase_config(input int phase);
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] s;
    logic [63:0] ideal;
    case (phase)
      1: begin r = CFG_MAX; s = CFG_W'(1); end
      2: begin r = CFG_W'(1); s = CFG_MAX; end
      3: begin r = CFG_MAX; s = CFG_MAX; end
      4: begin r = '0; s = CFG_MAX; end
      7: begin r = CFG_MAX; s = '0; end
      default: begin
        r = CFG_W'($urandom_range(4096, 1 << 26));
        ideal = (64'(LAST_ENTRY) << 32) / 64'(r);
        // nudge the scale up a little so the clamp at the top gets hit too
        if ($urandom_range(0, 1)) ideal = ideal + (ideal >> $urandom_range(5, 12));
        s = CFG_W'(ideal);
      end
    endcase
    drain();
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_INDEX_SCALE, s);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      profile_mem[e] = '0;
      gradient_mem[e] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 8);

    // directed part under the reset register values
    foreach (directed_rows[i])
      issue(directed_rows[i].op, directed_rows[i].entry, directed_rows[i].data,
            directed_rows[i].distance, directed_rows[i].pinned, directed_rows[i].result);
    run_random(ITEMS_PER_PHASE);

    for (int p = 1; p < PHASES; p++) begin
      set_phase_config(p);
      run_random(ITEMS_PER_PHASE);
    end

    drain();
    $display("Ran %0d transactions, %0d evaluations checked, over %0d register settings.",
             sent, evals_checked, PHASES);
    $display("Settings spanned zero, unit and full-scale radius and index scale.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: give up if the run hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results pending",
             cycle_count, pending_evals.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
